@@ rtl/skt_pkg.sv @@
`timescale 1ns / 1ps

package skt_pkg;

  localparam int KEY_PORT_W = 64;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef struct packed {
    logic ins_en;
    logic rem_en;
  } cell_ctl_t;

  typedef struct packed {
    logic ge;
    logic eq;
    logic after;
  } cell_flags_t;

endpackage

@@ rtl/skt_cell.sv @@
`timescale 1ns / 1ps

module skt_cell #(
  parameter int KEY_BITS = 64
) (
  input  logic                  clk,
  input  logic                  occ,
  input  logic [KEY_BITS-1:0]   in_key,
  input  skt_pkg::cell_ctl_t    ctl,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic                  left_after,
  input  logic [KEY_BITS-1:0]   right_key,
  output logic [KEY_BITS-1:0]   key_r,
  output skt_pkg::cell_flags_t  flags
);

  logic [KEY_BITS-1:0] key_nxt;

  always_comb begin
    flags.ge    = occ && (key_r >= in_key);
    flags.eq    = occ && (key_r == in_key);
    flags.after = !occ || (key_r > in_key);
  end

  always_comb begin
    key_nxt = key_r;
    if (ctl.ins_en && flags.after) begin
      key_nxt = left_after ? left_key : in_key;
    end else if (ctl.rem_en && flags.ge) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

@@ rtl/sorted_key_table.sv @@
`timescale 1ns / 1ps

// Sorted key table: keeps up to TABLE_DEPTH keys in ascending unsigned order in a row
// of cells, one key per cell. Insert, remove and search each take one request per
// cycle while results are taken; the result appears in the output register on the
// cycle after the request is accepted, and a new request is taken only in a cycle in
// which the output register is empty or its result is taken, so a stalled output
// holds off the input. Every cell compares its key with the request key at once and
// shifts toward or from its neighbor in the same cycle, so the compare across the row,
// the first-match encode and the count update set the cycle. Inserts into a full table
// are dropped and flagged by out_full_drop. Only the low KEY_BITS bits of in_key take
// part.
module sorted_key_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int KEY_BITS    = 64,
  localparam int PW = $clog2(TABLE_DEPTH),
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_op,
  input  logic [skt_pkg::KEY_PORT_W-1:0] in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic [PW-1:0]                  out_position,
  output logic [CW-1:0]                  out_entry_count,
  output logic                           out_full_drop
);

  logic [KEY_BITS-1:0]  key_m;
  logic [KEY_BITS-1:0]  cell_key [TABLE_DEPTH];
  skt_pkg::cell_flags_t cell_flags [TABLE_DEPTH];
  skt_pkg::cell_ctl_t   ctl;
  logic [TABLE_DEPTH-1:0] ins_sel;
  logic [TABLE_DEPTH-1:0] eq_sel;
  logic [TABLE_DEPTH-1:0] eq_vec;

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_hit_r, out_hit_nxt;
  logic [PW-1:0] out_position_r, out_position_nxt;
  logic [CW-1:0] out_entry_count_r, out_entry_count_nxt;
  logic          out_full_drop_r, out_full_drop_nxt;

  logic accept, full, found, is_ins, is_rem, is_srch;
  logic [PW-1:0] ins_pos, eq_pos;

  assign key_m    = in_key[KEY_BITS-1:0];
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign is_ins   = (in_op == skt_pkg::OP_INSERT);
  assign is_rem   = (in_op == skt_pkg::OP_REMOVE);
  assign is_srch  = (in_op == skt_pkg::OP_SEARCH);
  assign found    = |eq_vec;

  always_comb begin
    ctl.ins_en = accept && is_ins && !full;
    ctl.rem_en = accept && is_rem && found;
  end

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [KEY_BITS-1:0] lk;
      logic                la;
      logic [KEY_BITS-1:0] rk;
      if (g == 0) begin : g_first
        assign lk = key_m;
        assign la = 1'b0;
      end else begin : g_mid
        assign lk = cell_key[g-1];
        assign la = cell_flags[g-1].after;
      end
      if (g == TABLE_DEPTH - 1) begin : g_last
        assign rk = cell_key[g];
      end else begin : g_inner
        assign rk = cell_key[g+1];
      end

      skt_cell #(
        .KEY_BITS(KEY_BITS)
      ) u_cell (
        .clk       (clk),
        .occ       (CW'(g) < count_r),
        .in_key    (key_m),
        .ctl       (ctl),
        .left_key  (lk),
        .left_after(la),
        .right_key (rk),
        .key_r     (cell_key[g]),
        .flags     (cell_flags[g])
      );

      assign eq_vec[g] = cell_flags[g].eq;
      if (g == 0) begin : g_sel0
        assign ins_sel[g] = cell_flags[g].after;
        assign eq_sel[g]  = cell_flags[g].eq;
      end else begin : g_seln
        assign ins_sel[g] = cell_flags[g].after && !cell_flags[g-1].after;
        assign eq_sel[g]  = cell_flags[g].eq && !cell_flags[g-1].ge;
      end
    end
  endgenerate

  always_comb begin
    ins_pos = '0;
    eq_pos  = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ins_sel[i]) ins_pos = ins_pos | PW'(i);
      if (eq_sel[i])  eq_pos  = eq_pos  | PW'(i);
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt       = out_valid_r;
    out_hit_nxt         = out_hit_r;
    out_position_nxt    = out_position_r;
    out_entry_count_nxt = out_entry_count_r;
    out_full_drop_nxt   = out_full_drop_r;
    if (accept) begin
      out_valid_nxt       = 1'b1;
      out_hit_nxt         = 1'b0;
      out_position_nxt    = '0;
      out_full_drop_nxt   = 1'b0;
      out_entry_count_nxt = count_nxt;
      if (is_ins) begin
        if (full) begin
          out_full_drop_nxt = 1'b1;
        end else begin
          out_hit_nxt      = 1'b1;
          out_position_nxt = ins_pos;
        end
      end else if ((is_rem || is_srch) && found) begin
        out_hit_nxt      = 1'b1;
        out_position_nxt = eq_pos;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r         <= out_hit_nxt;
    out_position_r    <= out_position_nxt;
    out_entry_count_r <= out_entry_count_nxt;
    out_full_drop_r   <= out_full_drop_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_position    = out_position_r;
  assign out_entry_count = out_entry_count_r;
  assign out_full_drop   = out_full_drop_r;

endmodule
